[hdl/aragf_pkg.sv]
// Shared types, codes and helpers of the address range gap finder.
package aragf_pkg;

	localparam int ADDR_W         = 48;
	localparam int MAX_RANGES_DEF = 64;

	// The page size must be a power of two; rounding is an add and a mask.
	localparam int PAGE_BYTES = 4096;

	localparam logic [ADDR_W-1:0] DEFAULT_BASE_RST = 48'h0040_0000_0000;
	localparam logic [ADDR_W-1:0] UPPER_LIMIT_RST  = 48'h7FFF_FFFF_F000;

	localparam logic [1:0] KIND_ADD     = 2'd0;
	localparam logic [1:0] KIND_FIND    = 2'd1;
	localparam logic [1:0] KIND_RESERVE = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	localparam int         CFG_IDX_W        = 2;
	localparam logic [1:0] REG_DEFAULT_BASE = 2'd0;
	localparam logic [1:0] REG_UPPER_LIMIT  = 2'd1;

	typedef logic [ADDR_W-1:0] addr_t;
	// Rounded address with its carry bit on top; the carry marks a wrap.
	typedef logic [ADDR_W:0] rnd_t;

	// Priority signals rippling down the row of cells.
	typedef struct packed {
		logic hit;
		logic free;
	} chain_t;

	// Candidate range under test: [base, lim).
	typedef struct packed {
		addr_t base;
		addr_t lim;
	} cand_t;

	// Store command; only the lowest free cell takes it.
	typedef struct packed {
		logic  en;
		addr_t start;
		addr_t stop;
		rnd_t  stop_rnd;
	} wr_t;

	function automatic rnd_t page_round(input addr_t x);
		rnd_t s;
		s = {1'b0, x} + rnd_t'(PAGE_BYTES - 1);
		return s & ~rnd_t'(PAGE_BYTES - 1);
	endfunction

endpackage

[hdl/aragf_cell.sv]
// One table slot: stores a range, tests it against the candidate, joins the priority chains.
module aragf_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  aragf_pkg::chain_t    chain_in,
	output aragf_pkg::chain_t    chain_out,
	input  aragf_pkg::cand_t     cand,
	input  aragf_pkg::wr_t       wr,
	output logic                 hit_grant,
	output logic                 free_grant,
	output aragf_pkg::rnd_t      sel_rnd
);
	import aragf_pkg::*;

	logic  valid_q;
	addr_t start_q;
	addr_t stop_q;
	rnd_t  rnd_q;
	logic  hit_here;

	// Overlap unless the candidate ends at or before start, or begins at or after the end.
	assign hit_here = valid_q && (cand.lim > start_q) && (cand.base < stop_q);

	assign hit_grant  = hit_here && !chain_in.hit;
	assign free_grant = !valid_q && !chain_in.free;

	assign chain_out.hit  = chain_in.hit | hit_here;
	assign chain_out.free = chain_in.free | !valid_q;

	assign sel_rnd = hit_grant ? rnd_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr.en && free_grant) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && free_grant) begin
			start_q <= wr.start;
			stop_q  <= wr.stop;
			rnd_q   <= wr.stop_rnd;
		end
	end

endmodule

[hdl/address_range_gap_finder.sv]
// Top level of the address range gap finder: control sequencer and row of table cells.
//
// Usage. Items arrive on the in channel (kind, hint, length) and each one
// yields exactly one transfer on the out channel (base, status). kind 0 adds
// the range [hint, length) to the lowest free slot; kind 1 searches for the
// lowest page-aligned base at or above the hint (or default_base when the
// hint is zero) whose range of length bytes misses every stored range and
// stays below upper_limit; kind 2 does the same search and then stores the
// found range. Configuration writes arrive on the cfg channel, which is
// always ready, and must only be issued while the block is idle.
// An add goes from idle through the commit state to the done state, which loads
// the output register. A find goes through the start, move and scan states,
// repeating move and scan for each table entry the candidate jumps over (at
// most MAX_RANGES), then done; a reserve adds the commit state before done. In
// each scan all cells compare in parallel; each move adds the length to the new
// candidate base; this loop sets the rate, one item at a time. A new input
// transfer is taken as soon as the sequencer is back in idle, even while the
// previous result waits in the output register. A stalled receiver holds the
// result; the sequencer then waits before loading the next one. Reset empties
// the table and restores both configuration registers to their reset values.
module address_range_gap_finder #(
	parameter int MAX_RANGES = aragf_pkg::MAX_RANGES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        kind,
	input  logic [aragf_pkg::ADDR_W-1:0]      hint,
	input  logic [aragf_pkg::ADDR_W-1:0]      length,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [aragf_pkg::ADDR_W-1:0]      base,
	output logic [1:0]                        status,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [aragf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [aragf_pkg::ADDR_W-1:0]      cfg_data
);
	import aragf_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_MOVE,
		S_SCAN,
		S_COMMIT,
		S_DONE
	} state_t;

	state_t     state_q;
	logic [1:0] kind_q;
	addr_t      len_q;
	addr_t      base_q;
	addr_t      cand_end_q;
	rnd_t       sel_rnd_q;
	logic       first_q;
	addr_t      res_base_q;
	logic [1:0] res_status_q;
	logic       out_valid_q;
	addr_t      out_base_q;
	logic [1:0] out_status_q;
	addr_t      default_base_q;
	addr_t      upper_limit_q;

	chain_t                  chain [MAX_RANGES+1];
	rnd_t                    cell_rnd [MAX_RANGES];
	logic [MAX_RANGES-1:0]   hit_grant_vec;
	logic [MAX_RANGES-1:0]   free_grant_vec;
	cand_t                   cand;
	wr_t                     wr;
	rnd_t                    sel_or;
	rnd_t                    move_sum;
	logic                    any_hit;
	logic                    any_free;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign base      = out_base_q;
	assign status    = out_status_q;

	// The candidate and the store command share the same registers: in the
	// commit state base_q and cand_end_q hold the range to be stored.
	assign cand.base = base_q;
	assign cand.lim  = cand_end_q;

	assign wr.en       = (state_q == S_COMMIT);
	assign wr.start    = base_q;
	assign wr.stop     = cand_end_q;
	assign wr.stop_rnd = page_round(cand_end_q);

	// Both priority chains start empty at cell 0, so the lowest index wins.
	assign chain[0] = '0;

	for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
		aragf_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.chain_in   (chain[i]),
			.chain_out  (chain[i+1]),
			.cand       (cand),
			.wr         (wr),
			.hit_grant  (hit_grant_vec[i]),
			.free_grant (free_grant_vec[i]),
			.sel_rnd    (cell_rnd[i])
		);
	end

	assign any_hit  = chain[MAX_RANGES].hit;
	assign any_free = chain[MAX_RANGES].free;

	// At most one cell drives a nonzero value, so an OR picks the winner.
	always_comb begin
		sel_or = '0;
		for (int i = 0; i < MAX_RANGES; i++) begin
			sel_or = sel_or | cell_rnd[i];
		end
	end

	assign move_sum = {1'b0, sel_rnd_q[ADDR_W-1:0]} + {1'b0, len_q};

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_base_q <= DEFAULT_BASE_RST;
			upper_limit_q  <= UPPER_LIMIT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DEFAULT_BASE: default_base_q <= cfg_data;
				REG_UPPER_LIMIT:  upper_limit_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer. A search loops between the scan state, where every cell
	// tests the candidate, and the move state, where the candidate jumps to
	// the rounded end of the lowest hit entry. The first visit to the move
	// state takes the rounded starting address instead and skips the limit
	// test, as the starting point is only bounded by the final end check.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			kind_q       <= KIND_ADD;
			len_q        <= '0;
			base_q       <= '0;
			cand_end_q   <= '0;
			sel_rnd_q    <= '0;
			first_q      <= 1'b0;
			res_base_q   <= '0;
			res_status_q <= ST_OK;
			out_valid_q  <= 1'b0;
			out_base_q   <= '0;
			out_status_q <= ST_OK;
		end else begin
			// In the done state the output register is reloaded below instead.
			if (out_valid_q && out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						kind_q <= kind;
						len_q  <= length;
						priority case (kind)
							KIND_ADD: begin
								base_q     <= hint;
								cand_end_q <= length;
								state_q    <= S_COMMIT;
							end
							KIND_FIND, KIND_RESERVE: begin
								base_q  <= (hint != '0) ? hint : default_base_q;
								state_q <= S_START;
							end
							default: begin
								res_base_q   <= '0;
								res_status_q <= ST_NOSPACE;
								state_q      <= S_DONE;
							end
						endcase
					end
				end
				S_START: begin
					sel_rnd_q <= page_round(base_q);
					first_q   <= 1'b1;
					state_q   <= S_MOVE;
				end
				S_MOVE: begin
					if (sel_rnd_q[ADDR_W] || move_sum[ADDR_W] ||
					    (!first_q && (sel_rnd_q[ADDR_W-1:0] >= upper_limit_q))) begin
						res_base_q   <= '0;
						res_status_q <= ST_NOSPACE;
						state_q      <= S_DONE;
					end else begin
						base_q     <= sel_rnd_q[ADDR_W-1:0];
						cand_end_q <= move_sum[ADDR_W-1:0];
						first_q    <= 1'b0;
						state_q    <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (any_hit) begin
						sel_rnd_q <= sel_or;
						state_q   <= S_MOVE;
					end else if (cand_end_q > upper_limit_q) begin
						res_base_q   <= '0;
						res_status_q <= ST_NOSPACE;
						state_q      <= S_DONE;
					end else if (kind_q == KIND_RESERVE) begin
						state_q <= S_COMMIT;
					end else begin
						res_base_q   <= base_q;
						res_status_q <= ST_OK;
						state_q      <= S_DONE;
					end
				end
				S_COMMIT: begin
					if (any_free) begin
						res_base_q   <= base_q;
						res_status_q <= ST_OK;
					end else begin
						res_base_q   <= '0;
						res_status_q <= ST_FULL;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_base_q   <= res_base_q;
						out_status_q <= res_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// Only the lowest overlapping entry may steer the candidate.
	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_grant_vec))
		else $error("more than one cell granted as the hit entry");

	// A store lands in one slot at most.
	a_one_free: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(free_grant_vec))
		else $error("more than one cell granted as the free slot");

	// Every jump moves the candidate strictly upward, so the search ends.
	a_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MOVE && !first_q) |->
		(sel_rnd_q[ADDR_W] || (sel_rnd_q[ADDR_W-1:0] > base_q)))
		else $error("candidate did not advance past the hit entry");

	// The scanned range never wraps.
	a_no_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (cand_end_q >= base_q))
		else $error("candidate range wrapped during scan");

	// A failed item always reports a zero base.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != ST_OK)) |-> (base == '0))
		else $error("nonzero base with a failure status");
`endif

endmodule

[sim/gap_search_checker.sv]
// Checker for the address range gap finder: watches all three channels and predicts each result.
`timescale 1ns / 100ps

module gap_search_checker #(
	parameter int unsigned SLOTS = aragf_pkg::MAX_RANGES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic [1:0]                      kind,
	input  aragf_pkg::addr_t                hint,
	input  aragf_pkg::addr_t                length,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  aragf_pkg::addr_t                base,
	input  logic [1:0]                      status,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [aragf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  aragf_pkg::addr_t                cfg_data,
	output int unsigned                     pending,
	output int unsigned                     mismatches,
	output int unsigned                     n_ok,
	output int unsigned                     n_nospace,
	output int unsigned                     n_full,
	output int unsigned                     deepest
);
	import aragf_pkg::*;

	// Sums are formed in 64 bits so that a carry out of the 48-bit space stays visible.
	localparam logic [63:0] SPACE_MASK = 64'h0000_FFFF_FFFF_FFFF;
	localparam logic [63:0] PAGE       = 64'(PAGE_BYTES);

	typedef struct packed {
		addr_t      base;
		logic [1:0] status;
	} answer_t;

	addr_t   occ_start [SLOTS];
	addr_t   occ_end   [SLOTS];
	logic    occ_used  [SLOTS];
	addr_t   cur_default_base;
	addr_t   cur_upper_limit;
	answer_t pending_answers [$];

	function automatic logic page_up(input logic [63:0] x, output logic [63:0] r);
		r = ((x + PAGE - 64'd1) / PAGE) * PAGE;
		return r <= SPACE_MASK;
	endfunction

	// First-fit search: keep jumping past the lowest-numbered occupied range that the
	// candidate touches until nothing is touched, then check the candidate against the limit.
	function automatic logic search_gap(input addr_t from, input addr_t len, output addr_t found);
		logic [63:0]  cand;
		logic [63:0]  len64;
		logic         hit;
		int unsigned  hops;
		int unsigned  pass;
		int unsigned  slot;
		found = '0;
		hops  = 0;
		len64 = 64'(len);
		if (!page_up(64'(from != '0 ? from : cur_default_base), cand))
			return 1'b0;
		if (cand + len64 > SPACE_MASK)
			return 1'b0;
		for (pass = 0; pass <= SLOTS; pass++) begin
			hit = 1'b0;
			for (slot = 0; slot < SLOTS; slot++) begin
				if (!hit && occ_used[slot] &&
				    !(cand + len64 <= 64'(occ_start[slot]) || cand >= 64'(occ_end[slot]))) begin
					hit = 1'b1;
					hops++;
					if (hops > deepest)
						deepest = hops;
					if (!page_up(64'(occ_end[slot]), cand))
						return 1'b0;
				end
			end
			if (!hit)
				break;
			if (cand >= 64'(cur_upper_limit) || cand + len64 > SPACE_MASK)
				return 1'b0;
		end
		if (cand + len64 > 64'(cur_upper_limit))
			return 1'b0;
		found = cand[ADDR_W-1:0];
		return 1'b1;
	endfunction

	function automatic logic store_range(input addr_t lo, input addr_t hi);
		int unsigned slot;
		for (slot = 0; slot < SLOTS; slot++) begin
			if (!occ_used[slot]) begin
				occ_used[slot]  = 1'b1;
				occ_start[slot] = lo;
				occ_end[slot]   = hi;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic answer_t predict_answer(input logic [1:0] k, input addr_t h, input addr_t l);
		answer_t a;
		addr_t   found;
		a.base   = '0;
		a.status = ST_NOSPACE;
		case (k)
			KIND_ADD: begin
				if (store_range(h, l)) begin
					a.base   = h;
					a.status = ST_OK;
				end else begin
					a.status = ST_FULL;
				end
			end
			KIND_FIND, KIND_RESERVE: begin
				if (search_gap(h, l, found)) begin
					if (k == KIND_FIND || store_range(found, found + l)) begin
						a.base   = found;
						a.status = ST_OK;
					end else begin
						a.status = ST_FULL;
					end
				end
			end
			default: begin
			end
		endcase
		return a;
	endfunction

	task automatic report(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%s", msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		answer_t     want;
		int unsigned slot;
		if (!arst_n) begin
			cur_default_base = DEFAULT_BASE_RST;
			cur_upper_limit  = UPPER_LIMIT_RST;
			for (slot = 0; slot < SLOTS; slot++)
				occ_used[slot] = 1'b0;
			pending_answers.delete();
			pending    = 0;
			mismatches = 0;
			n_ok       = 0;
			n_nospace  = 0;
			n_full     = 0;
			deepest    = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DEFAULT_BASE: cur_default_base = cfg_data;
					REG_UPPER_LIMIT:  cur_upper_limit  = cfg_data;
					default: begin
					end
				endcase
			end
			// A result leaving at this edge belongs to an earlier request, so compare before
			// a request taken at the same edge is predicted.
			if (out_valid && out_ready) begin
				if (pending_answers.size() == 0) begin
					report($sformatf("unexpected result: base %h status %0d", base, status));
				end else begin
					want = pending_answers.pop_front();
					if (base !== want.base || status !== want.status)
						report($sformatf({"result mismatch: expected base %h status %0d,",
							" got base %h status %0d"},
							want.base, want.status, base, status));
					case (want.status)
						ST_OK:      n_ok++;
						ST_NOSPACE: n_nospace++;
						default:    n_full++;
					endcase
				end
			end
			if (in_valid && in_ready)
				pending_answers.push_back(predict_answer(kind, hint, length));
			pending = pending_answers.size();
		end
	end

endmodule

[sim/tb_address_range_gap_finder.sv]
// Testbench top for the address range gap finder: stimulus, receiver pacing and verdict.
`timescale 1ns / 100ps

module tb_address_range_gap_finder;
	import aragf_pkg::*;

	// Codes that the package leaves unnamed: the fourth request kind and the spare register slot.
	localparam logic [1:0]  KIND_UNUSED   = 2'd3;
	localparam logic [1:0]  REG_SPARE     = 2'd3;
	localparam int unsigned RUN_LIMIT     = 1_000_000;
	localparam int unsigned HOLD_CYCLES   = 400;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam addr_t       ALL_ONES      = {ADDR_W{1'b1}};
	localparam addr_t       PAGE          = addr_t'(PAGE_BYTES);
	// Most ranges and hints land in a window of a few hundred pages above the reset default
	// base, so stored ranges crowd each other and searches have to jump repeatedly.
	localparam int unsigned WINDOW_PAGES  = 400;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	logic [1:0]           kind      = KIND_FIND;
	addr_t                hint      = '0;
	addr_t                length    = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	addr_t                base;
	logic [1:0]           status;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_DEFAULT_BASE;
	addr_t                cfg_data  = '0;

	int unsigned pending;
	int unsigned mismatches;
	int unsigned n_ok;
	int unsigned n_nospace;
	int unsigned n_full;
	int unsigned deepest;

	// Pacing knobs. They are changed only at a rising edge, while the receiver process
	// reads them at falling edges, so a change never races with its use.
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_req       = 0;
	logic        hold_off       = 1'b0;
	int unsigned cycles         = 0;

	address_range_gap_finder u_top (.*);

	gap_search_checker u_checker (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= RUN_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// The receiver stalls at random, and throughout while a hold-off stretch is running.
	always @(negedge clk) begin
		out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
	end

	// Long receiver hold-off, counted here on its own so that the sender keeps offering
	// requests meanwhile; the result register fills and the block has to refuse input.
	initial begin
		forever begin
			wait (hold_req != 0);
			@(posedge clk);
			hold_off <= 1'b1;
			repeat (hold_req) @(posedge clk);
			hold_off <= 1'b0;
			hold_req = 0;
		end
	end

	function automatic addr_t rand_addr();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[ADDR_W-1:0];
	endfunction

	// A page inside the crowded window, off the page grid about one time in five.
	function automatic addr_t cluster_addr();
		addr_t a;
		a = DEFAULT_BASE_RST + addr_t'($urandom_range(WINDOW_PAGES)) * PAGE;
		if ($urandom_range(4) == 0)
			a += addr_t'($urandom_range(1, PAGE_BYTES - 1));
		return a;
	endfunction

	// Every task here is entered and left at a falling edge. The sender idles a random
	// number of cycles first, then holds its request until the transfer takes place.
	task automatic send_request(input logic [1:0] k, input addr_t h, input addr_t l);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		kind     <= k;
		hint     <= h;
		length   <= l;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// Valid is dropped after each write and held low until the next falling edge, so it
	// is never lowered and raised again at the same edge.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input addr_t value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Stops offering requests and waits until every predicted result has come out, plus a
	// settling margin, so that the block is idle for a register write or the verdict.
	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// One register setting with one pacing pattern and a run of random requests. Finds
	// dominate; adds and reserves are kept rare so that the table fills only about halfway
	// through the run, and the second half sees searches against a full table and adds
	// that are refused.
	task automatic run_phase(input addr_t dflt, input addr_t limit, input int unsigned s_pct,
	                         input int unsigned r_pct, input int unsigned n, input logic hold);
		int unsigned sel;
		logic [1:0]  k;
		addr_t       h;
		addr_t       l;
		settle();
		write_reg(REG_DEFAULT_BASE, dflt);
		write_reg(REG_UPPER_LIMIT, limit);
		@(posedge clk);
		send_idle_pct  = s_pct;
		recv_stall_pct = r_pct;
		if (hold)
			hold_req = HOLD_CYCLES;
		@(negedge clk);
		repeat (n) begin
			sel = $urandom_range(99);
			if (sel < 4) begin
				// Adds: mostly a few pages inside the window, sometimes an inverted or empty
				// range, sometimes two arbitrary addresses.
				k   = KIND_ADD;
				h   = cluster_addr();
				sel = $urandom_range(9);
				if (sel < 8) begin
					l = h + addr_t'($urandom_range(1, 12)) * PAGE;
					if ($urandom_range(3) == 0)
						l -= addr_t'($urandom_range(1, PAGE_BYTES - 1));
				end else if (sel == 8) begin
					l = h - addr_t'($urandom_range(3)) * PAGE;
				end else begin
					h = rand_addr();
					l = rand_addr();
				end
			end else begin
				k = (sel < 9) ? KIND_RESERVE : ((sel < 12) ? KIND_UNUSED : KIND_FIND);
				// Hints: zero for the default base, the window, anywhere, just below the top
				// of the space where rounding wraps, or just below the reset limit.
				sel = $urandom_range(99);
				if (sel < 25)
					h = '0;
				else if (sel < 70)
					h = cluster_addr();
				else if (sel < 80)
					h = rand_addr();
				else if (sel < 90)
					h = ALL_ONES - addr_t'($urandom_range(2 * PAGE_BYTES));
				else
					h = UPPER_LIMIT_RST - addr_t'($urandom_range(16)) * PAGE
					    + addr_t'($urandom_range(PAGE_BYTES - 1));
				sel = $urandom_range(99);
				if (sel < 10)
					l = '0;
				else if (sel < 70)
					l = addr_t'($urandom_range(1, 16)) * PAGE;
				else if (sel < 88)
					l = addr_t'($urandom_range(1, 2 * PAGE_BYTES));
				else
					l = rand_addr();
			end
			send_request(k, h, l);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed requests at the reset settings, table empty at first.
		// An empty table returns the default base, also for a zero length.
		send_request(KIND_FIND, '0, PAGE);
		send_request(KIND_FIND, '0, '0);
		// Rounding the hint up carries out of the address space.
		send_request(KIND_FIND, ALL_ONES, 48'd1);
		// The hint is aligned but base plus length leaves the address space.
		send_request(KIND_FIND, ALL_ONES - PAGE + 48'd1, ALL_ONES);
		// An unaligned hint is rounded up to the next page.
		send_request(KIND_FIND, PAGE + 48'd1, PAGE);
		// A range ending exactly at the limit fits; one byte more does not.
		send_request(KIND_FIND, UPPER_LIMIT_RST - PAGE, PAGE);
		send_request(KIND_FIND, UPPER_LIMIT_RST - PAGE, PAGE + 48'd1);
		// Two adjacent ranges at the default base, the second ending off the page grid; a
		// search from the default base must jump over both.
		send_request(KIND_ADD, DEFAULT_BASE_RST, DEFAULT_BASE_RST + 48'h3000);
		send_request(KIND_ADD, DEFAULT_BASE_RST + 48'h3000, DEFAULT_BASE_RST + 48'h5800);
		send_request(KIND_FIND, '0, PAGE);
		// Reserve takes the same gap, so the next search has to go past it.
		send_request(KIND_RESERVE, '0, 2 * PAGE);
		send_request(KIND_FIND, '0, PAGE);
		// An inverted entry still blocks a candidate that straddles both of its ends.
		send_request(KIND_ADD, DEFAULT_BASE_RST + 48'h2_0000, DEFAULT_BASE_RST + 48'h1_0000);
		send_request(KIND_FIND, DEFAULT_BASE_RST + 48'h9000, 48'h2_0000);
		// An empty entry blocks a candidate that spans its single address.
		send_request(KIND_ADD, DEFAULT_BASE_RST + 48'h4_0000, DEFAULT_BASE_RST + 48'h4_0000);
		send_request(KIND_FIND, DEFAULT_BASE_RST + 48'h3_F000, 2 * PAGE);
		// An entry across the limit pushes the candidate to or past the limit.
		send_request(KIND_ADD, UPPER_LIMIT_RST - 2 * PAGE, UPPER_LIMIT_RST + 48'h10);
		send_request(KIND_FIND, UPPER_LIMIT_RST - PAGE, '0);
		// An entry ending in the last page: jumping past it wraps the address space.
		send_request(KIND_ADD, ALL_ONES - 48'hFFFF, ALL_ONES - 48'hFFE);
		send_request(KIND_FIND, ALL_ONES - 48'hFFFF, PAGE);
		// The unused kind, and adds at the extremes of both fields.
		send_request(KIND_UNUSED, ALL_ONES, ALL_ONES);
		send_request(KIND_ADD, ALL_ONES, '0);
		send_request(KIND_ADD, '0, '0);

		// Random phases. The first starts with the long receiver hold-off while requests
		// keep coming back to back; the next two take both registers to their extremes.
		run_phase(DEFAULT_BASE_RST, UPPER_LIMIT_RST, 0, 0, 300, 1'b1);
		run_phase('0, ALL_ONES, 59, 0, 260, 1'b0);
		settle();
		write_reg(REG_SPARE, rand_addr());
		run_phase(ALL_ONES, '0, 0, 59, 80, 1'b0);
		run_phase(DEFAULT_BASE_RST + 48'h1234, DEFAULT_BASE_RST + 48'h18_0000, 25, 25, 330, 1'b0);
		run_phase(DEFAULT_BASE_RST, ALL_ONES, 0, 59, 420, 1'b0);
		settle();

		$display("%0d results checked over directed cases and five register settings: %0d ok, %0d no space, %0d table full",
			n_ok + n_nospace + n_full, n_ok, n_nospace, n_full);
		$display("longest search jumped %0d stored ranges; receiver held off once for %0d cycles",
			deepest, HOLD_CYCLES);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

[sim.f]
hdl/aragf_pkg.sv
hdl/aragf_cell.sv
hdl/address_range_gap_finder.sv
sim/gap_search_checker.sv
sim/tb_address_range_gap_finder.sv
